// ----- rtl/core/ndda_pkg.sv -----
// Package for the NVFP4 dequantize, dot and accumulate block.
// Holds fp32 constants, the scale and weight decoders and a leading-zero count.
// No dependencies.
`default_nettype none

package ndda_pkg;

   localparam int unsigned ExpW = 12;
   typedef logic signed [ExpW-1:0] exp_type;

   localparam logic [31:0] QNAN32       = 32'h7FC0_0000;
   localparam logic [31:0] INF32        = 32'h7F80_0000;
   localparam logic [31:0] NEG_ZERO32   = 32'h8000_0000;
   localparam logic [31:0] POS_ZERO32   = 32'h0000_0000;
   localparam logic [31:0] GLOBAL_SCALE_RESET = 32'h3F80_0000;

   // Decode an e4m3 scale byte into an fp32 pattern.
   function automatic logic [31:0] e4m3_bits(input logic [7:0] x);
      logic [3:0]  ex;
      logic [2:0]  m;
      logic [31:0] v;
      ex = x[6:3];
      m  = x[2:0];
      if (ex == 4'd15 && m == 3'd7) begin
         return QNAN32;
      end
      if (ex == 4'd0) begin
         if (m == 3'd0) begin
            v = 32'd0;
         end else if (m[2]) begin
            v = {1'b0, 8'd120, m[1:0], 21'd0};
         end else if (m[1]) begin
            v = {1'b0, 8'd119, m[0], 22'd0};
         end else begin
            v = {1'b0, 8'd118, 23'd0};
         end
      end else begin
         v = {1'b0, 8'({4'd0, ex} + 8'd120), m, 20'd0};
      end
      return {x[7], v[30:0]};
   endfunction

   // Decode one e2m1 weight code into an fp32 pattern.
   function automatic logic [31:0] fp4_bits(input logic [3:0] c);
      logic [30:0] mag;
      unique case (c[2:0])
         3'd0: mag = 31'h0000_0000;
         3'd1: mag = 31'h3F00_0000;
         3'd2: mag = 31'h3F80_0000;
         3'd3: mag = 31'h3FC0_0000;
         3'd4: mag = 31'h4000_0000;
         3'd5: mag = 31'h4040_0000;
         3'd6: mag = 31'h4080_0000;
         default: mag = 31'h40C0_0000;
      endcase
      return {c[3], mag};
   endfunction

   // Leading-zero count of a 64-bit word; 64 when the word is zero.
   function automatic logic [6:0] lzc64(input logic [63:0] v);
      logic [6:0] n;
      n = 7'd64;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) n = 7'(63 - i);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ndda_fma.sv -----
// Five-stage fp32 fused multiply-add, round to nearest even, one rounding.
// Depends on ndda_pkg.
`default_nettype none

module ndda_fma (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   input  wire logic [31:0] op_c,
   output logic             done,
   output logic [31:0]      result
);

   typedef struct packed {
      logic                 spec;
      logic [31:0]          spec_val;
      logic                 sp;
      logic                 sc;
      logic                 cz;
      logic [47:0]          mp;
      ndda_pkg::exp_type    ep;
      logic [23:0]          mc;
      ndda_pkg::exp_type    ec;
   } s1_type;

   typedef struct packed {
      logic                 spec;
      logic [31:0]          spec_val;
      logic                 sp;
      logic                 sc;
      logic                 cz;
      logic [63:0]          mp;
      ndda_pkg::exp_type    ep;
      logic [63:0]          mc;
      ndda_pkg::exp_type    ec;
   } s2_type;

   typedef struct packed {
      logic                 spec;
      logic [31:0]          spec_val;
      logic                 zero;
      logic                 sx;
      logic [63:0]          r;
      ndda_pkg::exp_type    ex;
   } s3_type;

   typedef struct packed {
      logic                 spec;
      logic [31:0]          spec_val;
      logic                 zero;
      logic                 sx;
      logic                 ovf;
      logic [63:0]          rn;
      ndda_pkg::exp_type    be;
      logic [6:0]           sh;
   } s4_type;

   logic [4:0]  vld_ff, vld_in;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   s4_type      s4_ff, s4_in;
   logic [31:0] res_ff, res_in;

   // Stage one: special operands and the significand product.
   always_comb begin
      logic       sa, sb, sc, sp;
      logic [7:0] ea, eb, ec, eae, ebe, ece;
      logic [22:0] fa, fb, fc;
      logic       az, bz, cz;
      logic [23:0] ma, mb;
      sa = op_a[31]; sb = op_b[31]; sc = op_c[31]; sp = sa ^ sb;
      ea = op_a[30:23]; eb = op_b[30:23]; ec = op_c[30:23];
      fa = op_a[22:0]; fb = op_b[22:0]; fc = op_c[22:0];
      az = (op_a[30:0] == 31'd0);
      bz = (op_b[30:0] == 31'd0);
      cz = (op_c[30:0] == 31'd0);
      eae = (ea != 8'd0) ? ea : 8'd1;
      ebe = (eb != 8'd0) ? eb : 8'd1;
      ece = (ec != 8'd0) ? ec : 8'd1;
      ma = {(ea != 8'd0), fa};
      mb = {(eb != 8'd0), fb};
      s1_in.sp = sp;
      s1_in.sc = sc;
      s1_in.cz = cz;
      s1_in.mp = ma * mb;
      s1_in.ep = $signed({4'd0, eae}) + $signed({4'd0, ebe}) - 12'sd300;
      s1_in.mc = {(ec != 8'd0), fc};
      s1_in.ec = $signed({4'd0, ece}) - 12'sd150;
      s1_in.spec = 1'b1;
      s1_in.spec_val = ndda_pkg::QNAN32;
      priority if ((ea == 8'hFF && fa != 23'd0) || (eb == 8'hFF && fb != 23'd0)
                   || (ec == 8'hFF && fc != 23'd0)) begin
         s1_in.spec_val = ndda_pkg::QNAN32;
      end else if (ea == 8'hFF || eb == 8'hFF) begin
         if (az || bz || (ec == 8'hFF && sc != sp)) begin
            s1_in.spec_val = ndda_pkg::QNAN32;
         end else begin
            s1_in.spec_val = {sp, ndda_pkg::INF32[30:0]};
         end
      end else if (ec == 8'hFF) begin
         s1_in.spec_val = op_c;
      end else if (az || bz) begin
         s1_in.spec_val = (!cz || sp == sc) ? op_c : ndda_pkg::POS_ZERO32;
      end else begin
         s1_in.spec = 1'b0;
      end
   end

   // Stage two: normalize product and addend to bit 60.
   always_comb begin
      logic [6:0] lzp, lzc;
      lzp = ndda_pkg::lzc64({16'd0, s1_ff.mp});
      lzc = ndda_pkg::lzc64({40'd0, s1_ff.mc});
      s2_in.spec = s1_ff.spec;
      s2_in.spec_val = s1_ff.spec_val;
      s2_in.sp = s1_ff.sp;
      s2_in.sc = s1_ff.sc;
      s2_in.cz = s1_ff.cz;
      s2_in.mp = {16'd0, s1_ff.mp} << (lzp - 7'd3);
      s2_in.ep = s1_ff.ep - $signed({5'd0, lzp}) + 12'sd3;
      s2_in.mc = {40'd0, s1_ff.mc} << (lzc - 7'd3);
      s2_in.ec = s1_ff.ec - $signed({5'd0, lzc}) + 12'sd3;
   end

   // Stage three: align the smaller operand with a sticky bit, then add.
   always_comb begin
      logic              c_big;
      logic [63:0]       mx, my, shv, sum;
      ndda_pkg::exp_type ex, d;
      logic              sx, sy;
      logic [5:0]        dcl;
      logic [127:0]      wide;
      c_big = (s2_ff.ec > s2_ff.ep) || (s2_ff.ec == s2_ff.ep && s2_ff.mc > s2_ff.mp);
      if (c_big) begin
         mx = s2_ff.mc; ex = s2_ff.ec; sx = s2_ff.sc;
         my = s2_ff.mp; d = s2_ff.ec - s2_ff.ep; sy = s2_ff.sp;
      end else begin
         mx = s2_ff.mp; ex = s2_ff.ep; sx = s2_ff.sp;
         my = s2_ff.mc; d = s2_ff.ep - s2_ff.ec; sy = s2_ff.sc;
      end
      dcl = (d > 12'sd63) ? 6'd63 : d[5:0];
      wide = {my, 64'd0} >> dcl;
      shv = wide[127:64] | {63'd0, (wide[63:0] != 64'd0)};
      sum = (sx == sy) ? (mx + shv) : (mx - shv);
      s3_in.spec = s2_ff.spec;
      s3_in.spec_val = s2_ff.spec_val;
      if (s2_ff.cz) begin
         s3_in.r = s2_ff.mp;
         s3_in.ex = s2_ff.ep;
         s3_in.sx = s2_ff.sp;
         s3_in.zero = 1'b0;
      end else begin
         s3_in.r = sum;
         s3_in.ex = ex;
         s3_in.sx = sx;
         s3_in.zero = (sx != sy) && (sum == 64'd0);
      end
   end

   // Stage four: normalize the sum to bit 63 and find the rounding position.
   always_comb begin
      logic [6:0]        lz;
      ndda_pkg::exp_type be, t;
      lz = ndda_pkg::lzc64(s3_ff.r);
      be = s3_ff.ex - $signed({5'd0, lz}) + 12'sd190;
      t = 12'sd41 - be;
      s4_in.spec = s3_ff.spec;
      s4_in.spec_val = s3_ff.spec_val;
      s4_in.zero = s3_ff.zero;
      s4_in.sx = s3_ff.sx;
      s4_in.rn = s3_ff.r << lz;
      s4_in.be = be;
      s4_in.ovf = (be >= 12'sd255);
      if (be >= 12'sd1) begin
         s4_in.sh = 7'd40;
      end else if (t > 12'sd65) begin
         s4_in.sh = 7'd65;
      end else begin
         s4_in.sh = t[6:0];
      end
   end

   // Stage five: round to nearest even and pack.
   always_comb begin
      logic [127:0] wide;
      logic [63:0]  q, rem;
      logic [31:0]  base;
      logic         up;
      wide = {s4_ff.rn, 64'd0} >> s4_ff.sh;
      q = wide[127:64];
      rem = wide[63:0];
      up = (rem > 64'h8000_0000_0000_0000) ||
           (rem == 64'h8000_0000_0000_0000 && q[0]);
      base = (s4_ff.be >= 12'sd1) ? {1'b0, 8'(s4_ff.be - 12'sd1), 23'd0} : 32'd0;
      base = base + q[31:0] + {31'd0, up};
      if (base >= ndda_pkg::INF32) base = ndda_pkg::INF32;
      priority if (s4_ff.spec) begin
         res_in = s4_ff.spec_val;
      end else if (s4_ff.zero) begin
         res_in = ndda_pkg::POS_ZERO32;
      end else if (s4_ff.ovf) begin
         res_in = {s4_ff.sx, ndda_pkg::INF32[30:0]};
      end else begin
         res_in = {s4_ff.sx, base[30:0]};
      end
   end

   assign vld_in = {vld_ff[3:0], start};

   // Stage valid chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      s4_ff  <= s4_in;
      res_ff <= res_in;
   end

   assign done   = vld_ff[4];
   assign result = res_ff;

endmodule

`default_nettype wire

// ----- rtl/core/nvfp4_dequant_dot_accumulate.sv -----
// Top level of the NVFP4 dequantize, dot and accumulate block.
// Depends on ndda_pkg and ndda_fma.
//
//   Channel | Direction | Handshake            | Contents
//   req     | in        | req_valid/req_ready  | scale, weight pair, two activations, last
//   rsp     | out       | rsp_valid/rsp_ready  | fp32 dot product on last words
//   csr     | in        | csr_wr_en            | global scale, fp32 pattern
//
// Each word is taken in the idle state, makes five passes through the one
// five-stage fused multiply-add (an issue state and a wait for the pipeline
// each), and the sum is retired in the final state.
// Reset sets the global scale to 1.0 and the running sum to +0.0.
// The result sits in an output register, so the next word is taken while a
// sum waits; a second last word stalls at its end until that register frees.
`default_nettype none

module nvfp4_dequant_dot_accumulate (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_scale_code,
   input  wire logic [7:0]  req_code_pair,
   input  wire logic [31:0] req_act_first,
   input  wire logic [31:0] req_act_second,
   input  wire logic        req_last_pair,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_dot_sum,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FIN} state_type;
   typedef enum logic [2:0] {
      STEP_SCALE, STEP_WA, STEP_WB, STEP_INNER, STEP_OUTER
   } step_type;

   state_type   state_ff, state_in;
   step_type    step_ff, step_in;
   logic [31:0] gscale_ff, gscale_in;
   logic [31:0] acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [7:0]  scale_ff, scale_in;
   logic [7:0]  pair_ff, pair_in;
   logic [31:0] act0_ff, act0_in, act1_ff, act1_in;
   logic        last_ff, last_in;
   logic [31:0] sc_ff, sc_in, wa_ff, wa_in, wb_ff, wb_in, tmp_ff, tmp_in;
   logic [31:0] res_ff, res_in;

   logic        fma_start, fma_done;
   logic [31:0] op_a, op_b, op_c, fma_res;

   ndda_fma u_fma (
      .clock  (clock),
      .reset  (reset),
      .start  (fma_start),
      .op_a   (op_a),
      .op_b   (op_b),
      .op_c   (op_c),
      .done   (fma_done),
      .result (fma_res)
   );

   // Operand selection for the current pass.
   always_comb begin
      unique case (step_ff)
         STEP_SCALE: begin
            op_a = ndda_pkg::e4m3_bits(scale_ff);
            op_b = gscale_ff;
            op_c = ndda_pkg::NEG_ZERO32;
         end
         STEP_WA: begin
            op_a = ndda_pkg::fp4_bits(pair_ff[3:0]);
            op_b = sc_ff;
            op_c = ndda_pkg::NEG_ZERO32;
         end
         STEP_WB: begin
            op_a = ndda_pkg::fp4_bits(pair_ff[7:4]);
            op_b = sc_ff;
            op_c = ndda_pkg::NEG_ZERO32;
         end
         STEP_INNER: begin
            op_a = wb_ff;
            op_b = act1_ff;
            op_c = acc_ff;
         end
         default: begin
            op_a = wa_ff;
            op_b = act0_ff;
            op_c = tmp_ff;
         end
      endcase
   end

   assign fma_start = (state_ff == ST_ISSUE);

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      gscale_in = csr_wr_en ? csr_wr_data : gscale_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      scale_in = scale_ff;
      pair_in = pair_ff;
      act0_in = act0_ff;
      act1_in = act1_ff;
      last_in = last_ff;
      sc_in = sc_ff;
      wa_in = wa_ff;
      wb_in = wb_ff;
      tmp_in = tmp_ff;
      res_in = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               scale_in = req_scale_code;
               pair_in = req_code_pair;
               act0_in = req_act_first;
               act1_in = req_act_second;
               last_in = req_last_pair;
               step_in = STEP_SCALE;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (fma_done) begin
               state_in = ST_ISSUE;
               unique case (step_ff)
                  STEP_SCALE: begin
                     sc_in = fma_res;
                     step_in = STEP_WA;
                  end
                  STEP_WA: begin
                     wa_in = fma_res;
                     step_in = STEP_WB;
                  end
                  STEP_WB: begin
                     wb_in = fma_res;
                     step_in = STEP_INNER;
                  end
                  STEP_INNER: begin
                     tmp_in = fma_res;
                     step_in = STEP_OUTER;
                  end
                  default: begin
                     res_in = fma_res;
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         default: begin
            if (!last_ff) begin
               acc_in = res_ff;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in = res_ff;
               rsp_valid_in = 1'b1;
               acc_in = ndda_pkg::POS_ZERO32;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Control state and the registered response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_SCALE;
         gscale_ff    <= ndda_pkg::GLOBAL_SCALE_RESET;
         acc_ff       <= ndda_pkg::POS_ZERO32;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         gscale_ff    <= gscale_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Word and intermediate payload registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      scale_ff    <= scale_in;
      pair_ff     <= pair_in;
      act0_ff     <= act0_in;
      act1_ff     <= act1_in;
      last_ff     <= last_in;
      sc_ff       <= sc_in;
      wa_ff       <= wa_in;
      wb_ff       <= wb_in;
      tmp_ff      <= tmp_in;
      res_ff      <= res_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_dot_sum = rsp_data_ff;

endmodule

`default_nettype wire
